FILE: hw/rtl/i2ctrf_pkg.sv
// types and constants shared by the i2c target register file
// no dependencies: compile this file first
package i2ctrf_pkg;

	// width of the register pointer and of the register count
	localparam int unsigned PTR_W  = 5;
	localparam int unsigned MASK_W = 16;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned EVIDX_W = 4;

	// value returned on a read with no valid register
	localparam logic [DATA_W-1:0] IDLE_BYTE = 8'hFF;

	// reset values of the configuration registers
	localparam logic [PTR_W-1:0]  COUNT_RESET = 5'd16;
	localparam logic [MASK_W-1:0] MASK_RESET  = 16'h0000;

	// bus operation codes
	typedef enum logic [1:0] {
		OP_START_WRITE = 2'd0,
		OP_START_READ  = 2'd1,
		OP_WRITE_BYTE  = 2'd2,
		OP_READ_BYTE   = 2'd3
	} op_e_t;

	// configuration register indexes
	typedef enum logic {
		CFG_REGISTER_COUNT = 1'b0,
		CFG_READONLY_MASK  = 1'b1
	} cfg_reg_t;

	// one input item
	typedef struct packed {
		op_e_t             operation;
		logic [DATA_W-1:0] write_byte_value;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic [DATA_W-1:0]  read_byte_value;
		logic [PTR_W-1:0]   remaining_count;
		logic               changed_event;
		logic [EVIDX_W-1:0] changed_index;
	} out_item_t;

	// write request from the pointer logic to the register array
	typedef struct packed {
		logic              en;
		logic [PTR_W-1:0]  idx;
		logic [DATA_W-1:0] data;
	} wr_req_t;

endpackage

FILE: hw/rtl/i2ctrf_regs.sv
// byte register array of the i2c target register file
// depends on i2ctrf_pkg
module i2ctrf_regs #(
	parameter int unsigned NUM_REGS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  i2ctrf_pkg::wr_req_t       wr_req,
	input  logic [i2ctrf_pkg::PTR_W-1:0] rd_idx,
	output logic [i2ctrf_pkg::DATA_W-1:0] rd_data
);

	localparam int unsigned IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int unsigned AW    = (IDX_W > i2ctrf_pkg::PTR_W) ? IDX_W : i2ctrf_pkg::PTR_W;

	logic [i2ctrf_pkg::DATA_W-1:0] regs_q [NUM_REGS];
	logic [AW-1:0]                 wr_addr_w;
	logic [AW-1:0]                 rd_addr_w;
	logic [IDX_W-1:0]              wr_addr;
	logic [IDX_W-1:0]              rd_addr;

	// pointer is always below the register count when used, so it fits the array
	assign wr_addr_w = AW'(wr_req.idx);
	assign rd_addr_w = AW'(rd_idx);
	assign wr_addr   = wr_addr_w[IDX_W-1:0];
	assign rd_addr   = rd_addr_w[IDX_W-1:0];

	// register storage, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(NUM_REGS); i++) begin
				regs_q[i] <= '0;
			end
		end else if (wr_req.en) begin
			regs_q[wr_addr] <= wr_req.data;
		end
	end

	// read of the pointed register, registered in the result stage
	assign rd_data = regs_q[rd_addr];

endmodule

FILE: hw/rtl/i2ctrf_ptr.sv
// register pointer and per-item decode of the i2c target register file
// depends on i2ctrf_pkg
module i2ctrf_ptr #(
	parameter int unsigned NUM_REGS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_s1,
	input  i2ctrf_pkg::in_item_t           item_s1,
	input  logic [i2ctrf_pkg::PTR_W-1:0]   count_q,
	input  logic [i2ctrf_pkg::MASK_W-1:0]  mask_q,
	input  logic [i2ctrf_pkg::DATA_W-1:0]  rd_data,
	output logic [i2ctrf_pkg::PTR_W-1:0]   ptr,
	output i2ctrf_pkg::wr_req_t            wr_req,
	output i2ctrf_pkg::out_item_t          res
);

	logic [i2ctrf_pkg::PTR_W-1:0] ptr_q;
	logic                         set_q;
	logic [i2ctrf_pkg::PTR_W-1:0] ptr_n;
	logic                         set_n;
	logic [i2ctrf_pkg::PTR_W-1:0] cnt;
	logic [i2ctrf_pkg::PTR_W-1:0] ptr_inc;
	logic                         in_range;
	logic                         ro_hit;

	// register count clamped to the size of the array
	assign cnt = (32'(count_q) > NUM_REGS) ? i2ctrf_pkg::PTR_W'(NUM_REGS) : count_q;

	assign ptr_inc  = ptr_q + 1'b1;
	assign in_range = ptr_q < cnt;
	// registers above the mask width are always writable
	assign ro_hit = !ptr_q[i2ctrf_pkg::PTR_W-1] &&
		mask_q[ptr_q[i2ctrf_pkg::EVIDX_W-1:0]];

	assign ptr = ptr_q;

	// next pointer, write request and result for the item in stage one
	always_comb begin
		ptr_n  = ptr_q;
		set_n  = set_q;
		wr_req = '0;
		res    = '0;
		wr_req.idx  = ptr_q;
		wr_req.data = item_s1.write_byte_value;
		unique case (item_s1.operation)
			i2ctrf_pkg::OP_START_WRITE: begin
				set_n = 1'b0;
				ptr_n = '0;
			end
			i2ctrf_pkg::OP_START_READ: begin
				set_n = set_q;
			end
			i2ctrf_pkg::OP_WRITE_BYTE: begin
				if (!set_q) begin
					// first byte selects the register
					if (item_s1.write_byte_value < {3'b000, cnt}) begin
						ptr_n = item_s1.write_byte_value[i2ctrf_pkg::PTR_W-1:0];
						set_n = 1'b1;
						res.remaining_count = cnt -
							item_s1.write_byte_value[i2ctrf_pkg::PTR_W-1:0];
					end
				end else if (in_range) begin
					if (!ro_hit) begin
						wr_req.en             = 1'b1;
						res.changed_event     = 1'b1;
						res.changed_index     = ptr_q[i2ctrf_pkg::EVIDX_W-1:0];
					end
					ptr_n               = ptr_inc;
					res.remaining_count = cnt - ptr_inc;
				end
			end
			default: begin
				// read byte
				if (!set_q || !in_range) begin
					res.read_byte_value = i2ctrf_pkg::IDLE_BYTE;
				end else begin
					res.read_byte_value = rd_data;
					ptr_n               = ptr_inc;
					res.remaining_count = cnt - ptr_inc;
				end
			end
		endcase
		if (!valid_s1) begin
			wr_req.en = 1'b0;
		end
	end

	// pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			set_q <= 1'b0;
		end else if (valid_s1) begin
			ptr_q <= ptr_n;
			set_q <= set_n;
		end
	end

endmodule

FILE: hw/rtl/i2ctrf_cfg.sv
// configuration registers of the i2c target register file
// depends on i2ctrf_pkg
module i2ctrf_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  i2ctrf_pkg::cfg_reg_t          wr_idx,
	input  logic [i2ctrf_pkg::MASK_W-1:0] wr_data,
	output logic [i2ctrf_pkg::PTR_W-1:0]  count_q,
	output logic [i2ctrf_pkg::MASK_W-1:0] mask_q
);

	// register writes decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= i2ctrf_pkg::COUNT_RESET;
			mask_q  <= i2ctrf_pkg::MASK_RESET;
		end else if (wr_en) begin
			unique case (wr_idx)
				i2ctrf_pkg::CFG_REGISTER_COUNT: count_q <= wr_data[i2ctrf_pkg::PTR_W-1:0];
				i2ctrf_pkg::CFG_READONLY_MASK:  mask_q  <= wr_data;
				default:                        mask_q  <= mask_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/i2c_target_register_file_unit.sv
// top level of the i2c target register file, bus side
// depends on i2ctrf_pkg, i2ctrf_cfg, i2ctrf_regs and i2ctrf_ptr
//
// Usage:
//   Input channel: an item (operation and write byte) is taken at a rising
//   edge with start high and busy low. busy is high while in reset and
//   until the next edge after it; then one item is taken each cycle.
//   Result channel: every item gives exactly one result, shown on result for
//   one cycle with result_valid high; it passes the input register and the
//   result register after the accepting edge.
//   The receiver cannot stall, so nothing is held back and no result waits.
//   Throughput is one item per cycle: the pointer is updated in the same
//   cycle the item is decoded, so the next item sees it straight away.
//   Configuration channel: cfg_index selects register count (0) or read-only
//   mask (1); written when cfg_valid and cfg_ready are high. Writes are
//   expected only while no item is in flight.
//   Reset: the byte registers, pointer and pointer flag clear; register count
//   returns to 16 and the mask to zero.
module i2c_target_register_file_unit #(
	parameter int unsigned NUM_REGS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  i2ctrf_pkg::in_item_t          item,
	output logic                          result_valid,
	output i2ctrf_pkg::out_item_t         result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  i2ctrf_pkg::cfg_reg_t          cfg_index,
	input  logic [i2ctrf_pkg::MASK_W-1:0] cfg_data
);

	logic                          busy_q;
	logic                          valid_s1;
	i2ctrf_pkg::in_item_t          item_s1;
	logic                          result_valid_q;
	i2ctrf_pkg::out_item_t         result_q;
	logic [i2ctrf_pkg::PTR_W-1:0]  count_q;
	logic [i2ctrf_pkg::MASK_W-1:0] mask_q;
	logic [i2ctrf_pkg::PTR_W-1:0]  ptr;
	logic [i2ctrf_pkg::DATA_W-1:0] rd_data;
	i2ctrf_pkg::wr_req_t           wr_req;
	i2ctrf_pkg::out_item_t         res;
	logic                          accept;

	assign busy      = busy_q;
	assign cfg_ready = !busy_q;
	assign accept    = start && !busy_q;

	// held busy through reset, cleared at the next edge after release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// configuration registers
	i2ctrf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.count_q (count_q),
		.mask_q  (mask_q)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// byte register array
	i2ctrf_regs #(
		.NUM_REGS (NUM_REGS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_req  (wr_req),
		.rd_idx  (ptr),
		.rd_data (rd_data)
	);

	// pointer and item decode
	i2ctrf_ptr #(
		.NUM_REGS (NUM_REGS)
	) u_ptr (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.count_q  (count_q),
		.mask_q   (mask_q),
		.rd_data  (rd_data),
		.ptr      (ptr),
		.wr_req   (wr_req),
		.res      (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	// every accepted item reaches the result stage via the input register
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 result_valid)
		else $error("accepted item gave no result");

	// no result without an item in stage one the cycle before
	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(valid_s1))
		else $error("result without an item");

	// a store never comes with read data
	a_event_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.changed_event |-> result.read_byte_value == '0)
		else $error("changed event together with read data");

	// register writes only happen for an item in stage one
	a_write_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		wr_req.en |-> valid_s1)
		else $error("register write without an item");
`endif

endmodule

FILE: tb/i2c_target_register_file_unit_tb.sv
// testbench for the i2c target register file, bus side: directed and random packets
// checked item by item against a shadow copy of the register map
// depends on i2ctrf_pkg and i2c_target_register_file_unit
`timescale 1ns / 100ps

module i2c_target_register_file_unit_tb;

	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned SETTLE_CYCLES  = 4;

	// shadow of the register map, pointer and settings; holds the results still due
	class regmap_shadow;
		localparam int unsigned NUM_SLOTS = 16;

		logic [i2ctrf_pkg::DATA_W-1:0] byte_regs [NUM_SLOTS];
		int unsigned                   ptr;
		bit                            ptr_valid;
		logic [i2ctrf_pkg::PTR_W-1:0]  reg_count;
		logic [i2ctrf_pkg::MASK_W-1:0] ro_mask;
		i2ctrf_pkg::out_item_t         due_results [$];
		int unsigned                   mismatches;

		function new();
			foreach (byte_regs[i]) byte_regs[i] = '0;
			ptr = 0;
			ptr_valid = 0;
			reg_count = i2ctrf_pkg::COUNT_RESET;
			ro_mask = i2ctrf_pkg::MASK_RESET;
			mismatches = 0;
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			mismatches++;
		endtask

		function void note_config(i2ctrf_pkg::cfg_reg_t idx,
			logic [i2ctrf_pkg::MASK_W-1:0] d);
			case (idx)
			i2ctrf_pkg::CFG_REGISTER_COUNT: reg_count = d[i2ctrf_pkg::PTR_W-1:0];
			i2ctrf_pkg::CFG_READONLY_MASK:  ro_mask = d;
			default:                        ;
			endcase
		endfunction

		// work out the result of one accepted item and move the shadow state on
		function void note_item(i2ctrf_pkg::in_item_t it);
			int unsigned           cnt;
			i2ctrf_pkg::out_item_t exp;
			cnt = (32'(reg_count) > NUM_SLOTS) ? NUM_SLOTS : 32'(reg_count);
			exp = '0;
			case (it.operation)
			i2ctrf_pkg::OP_START_WRITE: begin
				ptr_valid = 0;
				ptr = 0;
			end
			i2ctrf_pkg::OP_START_READ: begin
				// pointer kept as it is
			end
			i2ctrf_pkg::OP_WRITE_BYTE: begin
				if (!ptr_valid) begin
					// first byte selects a register, ignored when out of range
					if (32'(it.write_byte_value) < cnt) begin
						ptr = 32'(it.write_byte_value);
						ptr_valid = 1;
						exp.remaining_count = i2ctrf_pkg::PTR_W'(cnt - ptr);
					end
				end else if (ptr < cnt) begin
					// read-only registers drop the byte but the pointer still moves
					if (!ro_mask[ptr[3:0]]) begin
						byte_regs[ptr[3:0]] = it.write_byte_value;
						exp.changed_event = 1'b1;
						exp.changed_index = i2ctrf_pkg::EVIDX_W'(ptr);
					end
					ptr++;
					exp.remaining_count = i2ctrf_pkg::PTR_W'(cnt - ptr);
				end
			end
			default: begin
				if (!ptr_valid || ptr >= cnt) begin
					exp.read_byte_value = i2ctrf_pkg::IDLE_BYTE;
				end else begin
					exp.read_byte_value = byte_regs[ptr[3:0]];
					ptr++;
					exp.remaining_count = i2ctrf_pkg::PTR_W'(cnt - ptr);
				end
			end
			endcase
			due_results.push_back(exp);
		endfunction

		task check_result(i2ctrf_pkg::out_item_t got);
			i2ctrf_pkg::out_item_t exp;
			if (due_results.size() == 0) begin
				report($sformatf("result %h with no item pending", got));
				return;
			end
			exp = due_results.pop_front();
			if (got.read_byte_value !== exp.read_byte_value)
				report($sformatf("read_byte_value %h, expected %h",
					got.read_byte_value, exp.read_byte_value));
			if (got.remaining_count !== exp.remaining_count)
				report($sformatf("remaining_count %0d, expected %0d",
					got.remaining_count, exp.remaining_count));
			if (got.changed_event !== exp.changed_event)
				report($sformatf("changed_event %b, expected %b",
					got.changed_event, exp.changed_event));
			if (got.changed_index !== exp.changed_index)
				report($sformatf("changed_index %0d, expected %0d",
					got.changed_index, exp.changed_index));
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	i2ctrf_pkg::in_item_t          item;
	logic                          result_valid;
	i2ctrf_pkg::out_item_t         result;
	logic                          cfg_valid;
	logic                          cfg_ready;
	i2ctrf_pkg::cfg_reg_t          cfg_index;
	logic [i2ctrf_pkg::MASK_W-1:0] cfg_data;

	regmap_shadow                  shadow;
	int unsigned                   sent_items;
	int unsigned                   gap_pct;
	int unsigned                   quiet_cycles;
	logic [i2ctrf_pkg::PTR_W-1:0]  cur_count;

	i2c_target_register_file_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// note accepted items and settings, check results, watch for a hang
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			shadow.note_config(cfg_index, cfg_data);
		if (start && !busy)
			shadow.note_item(item);
		if (result_valid)
			shadow.check_result(result);
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// present one item, hold it until taken, then maybe leave a gap
	task automatic send_op(input i2ctrf_pkg::op_e_t op,
		input logic [i2ctrf_pkg::DATA_W-1:0] d);
		i2ctrf_pkg::in_item_t it;
		it.operation = op;
		it.write_byte_value = d;
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		sent_items++;
		// each following cycle idles with a chance of gap_pct in a hundred
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// stop sending and wait until every result is back
	task automatic settle();
		start <= 1'b0;
		while (shadow.due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both settings back to back, valid held high across the pair
	task automatic set_config(input logic [i2ctrf_pkg::PTR_W-1:0] count,
		input logic [i2ctrf_pkg::MASK_W-1:0] mask);
		cfg_valid <= 1'b1;
		cfg_index <= i2ctrf_pkg::CFG_REGISTER_COUNT;
		cfg_data <= i2ctrf_pkg::MASK_W'(count);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= i2ctrf_pkg::CFG_READONLY_MASK;
		cfg_data <= mask;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_count = count;
	endtask

	task automatic random_config();
		logic [i2ctrf_pkg::PTR_W-1:0]  count;
		logic [i2ctrf_pkg::MASK_W-1:0] mask;
		case ($urandom_range(9))
		0:       count = '0;
		1:       count = i2ctrf_pkg::PTR_W'(1);
		2:       count = i2ctrf_pkg::PTR_W'(16);
		3:       count = i2ctrf_pkg::PTR_W'($urandom_range(17, 31));
		default: count = i2ctrf_pkg::PTR_W'($urandom_range(1, 16));
		endcase
		case ($urandom_range(3))
		0:       mask = '0;
		1:       mask = '1;
		default: mask = i2ctrf_pkg::MASK_W'($urandom);
		endcase
		set_config(count, mask);
	endtask

	// one bus transaction: mostly well formed, sometimes plain noise
	task automatic run_packet();
		int unsigned eff;
		int unsigned sel;
		int unsigned kind;
		eff = (32'(cur_count) > 16) ? 16 : 32'(cur_count);
		kind = $urandom_range(9);
		if (eff == 0 || $urandom_range(7) == 0)
			sel = $urandom_range(255);
		else
			sel = $urandom_range(eff - 1);
		if (kind <= 3) begin
			// register write with auto increment
			send_op(i2ctrf_pkg::OP_START_WRITE, i2ctrf_pkg::DATA_W'($urandom));
			send_op(i2ctrf_pkg::OP_WRITE_BYTE, i2ctrf_pkg::DATA_W'(sel));
			repeat ($urandom_range(eff + 2))
				send_op(i2ctrf_pkg::OP_WRITE_BYTE, i2ctrf_pkg::DATA_W'($urandom));
		end else if (kind <= 6) begin
			// pointer set then repeated start for reading
			send_op(i2ctrf_pkg::OP_START_WRITE, i2ctrf_pkg::DATA_W'($urandom));
			send_op(i2ctrf_pkg::OP_WRITE_BYTE, i2ctrf_pkg::DATA_W'(sel));
			send_op(i2ctrf_pkg::OP_START_READ, i2ctrf_pkg::DATA_W'($urandom));
			repeat ($urandom_range(eff + 2))
				send_op(i2ctrf_pkg::OP_READ_BYTE, i2ctrf_pkg::DATA_W'($urandom));
		end else if (kind == 7) begin
			// read carrying on from the current pointer
			send_op(i2ctrf_pkg::OP_START_READ, i2ctrf_pkg::DATA_W'($urandom));
			repeat ($urandom_range(1, 6))
				send_op(i2ctrf_pkg::OP_READ_BYTE, i2ctrf_pkg::DATA_W'($urandom));
		end else begin
			repeat ($urandom_range(1, 6))
				send_op(i2ctrf_pkg::op_e_t'($urandom_range(3)),
					i2ctrf_pkg::DATA_W'($urandom));
		end
	endtask

	initial begin
		int unsigned target;
		int unsigned next_cfg;
		shadow = new();
		sent_items = 0;
		gap_pct = 0;
		cur_count = i2ctrf_pkg::COUNT_RESET;
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= i2ctrf_pkg::CFG_REGISTER_COUNT;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, pointer cleared, out of range and past the end
		send_op(i2ctrf_pkg::OP_READ_BYTE, 8'h00);
		send_op(i2ctrf_pkg::OP_START_WRITE, 8'h00);
		send_op(i2ctrf_pkg::OP_WRITE_BYTE, 8'd16);
		send_op(i2ctrf_pkg::OP_WRITE_BYTE, 8'hFF);
		send_op(i2ctrf_pkg::OP_WRITE_BYTE, 8'd14);
		send_op(i2ctrf_pkg::OP_WRITE_BYTE, 8'hFF);
		send_op(i2ctrf_pkg::OP_WRITE_BYTE, 8'h5A);
		send_op(i2ctrf_pkg::OP_WRITE_BYTE, 8'h33);
		send_op(i2ctrf_pkg::OP_START_READ, 8'hFF);
		send_op(i2ctrf_pkg::OP_READ_BYTE, 8'hFF);
		send_op(i2ctrf_pkg::OP_START_WRITE, 8'hFF);
		send_op(i2ctrf_pkg::OP_WRITE_BYTE, 8'd14);
		send_op(i2ctrf_pkg::OP_START_READ, 8'h00);
		send_op(i2ctrf_pkg::OP_READ_BYTE, 8'h00);
		send_op(i2ctrf_pkg::OP_READ_BYTE, 8'h00);
		send_op(i2ctrf_pkg::OP_READ_BYTE, 8'h00);
		// every register read-only, short map
		settle();
		set_config(5'd4, 16'hFFFF);
		send_op(i2ctrf_pkg::OP_START_WRITE, 8'h00);
		send_op(i2ctrf_pkg::OP_WRITE_BYTE, 8'd3);
		send_op(i2ctrf_pkg::OP_WRITE_BYTE, 8'h77);
		send_op(i2ctrf_pkg::OP_READ_BYTE, 8'h00);
		// empty map
		settle();
		set_config(5'd0, 16'h0000);
		send_op(i2ctrf_pkg::OP_START_WRITE, 8'h00);
		send_op(i2ctrf_pkg::OP_WRITE_BYTE, 8'h00);
		send_op(i2ctrf_pkg::OP_READ_BYTE, 8'h00);
		// count above the map size acts as the full map
		settle();
		set_config(5'd31, 16'h5555);
		send_op(i2ctrf_pkg::OP_START_WRITE, 8'h00);
		send_op(i2ctrf_pkg::OP_WRITE_BYTE, 8'd15);
		send_op(i2ctrf_pkg::OP_WRITE_BYTE, 8'h81);
		// count lowered below the pointer mid packet
		send_op(i2ctrf_pkg::OP_START_WRITE, 8'h00);
		send_op(i2ctrf_pkg::OP_WRITE_BYTE, 8'd8);
		settle();
		set_config(5'd5, 16'h0000);
		send_op(i2ctrf_pkg::OP_WRITE_BYTE, 8'h42);
		send_op(i2ctrf_pkg::OP_READ_BYTE, 8'h00);

		// random packets in three idling phases, settings changed now and then
		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = (ph == 0) ? 35 : (ph == 1) ? 59 : 0;
			target = sent_items + 350;
			next_cfg = sent_items;
			while (sent_items < target) begin
				if (sent_items >= next_cfg) begin
					settle();
					random_config();
					next_cfg = sent_items + $urandom_range(40, 90);
				end
				run_packet();
			end
		end

		settle();
		if (shadow.due_results.size() != 0)
			shadow.report($sformatf("%0d results never arrived",
				shadow.due_results.size()));
		if (shadow.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
